>>> hdl/bdtn_pkg.sv
// Shared types and constants for the button debounce and toggle notifier.
package bdtn_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int NUM_RELAYS  = 8;
  localparam int RING_DEPTH  = 16;

  localparam int BTN_W    = $clog2(NUM_BUTTONS);
  localparam int RELAY_W  = $clog2(NUM_RELAYS);
  localparam int RING_AW  = $clog2(RING_DEPTH);
  localparam int CNT_W    = 4;
  localparam int TIME_W   = 32;
  localparam int DEB_W    = 16;
  localparam int OP_W     = 2;
  localparam int MAP_W    = NUM_BUTTONS * RELAY_W;

  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET_MS = 16'd50;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_SYNC   = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  // notice kinds
  localparam logic KIND_LOCAL  = 1'b0;
  localparam logic KIND_REMOTE = 1'b1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_BUTTON_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOCAL_MASK    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELAY_MAP     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd4;

  typedef struct packed {
    logic [CNT_W-1:0]       button_count;
    logic [NUM_BUTTONS-1:0] enable_mask;
    logic [NUM_BUTTONS-1:0] local_mask;
    logic [MAP_W-1:0]       relay_map;
    logic [DEB_W-1:0]       debounce_ms;
  } cfg_t;

  // per-button debounce state kept in the button memory
  typedef struct packed {
    logic              raw;
    logic              stable;
    logic [TIME_W-1:0] ctime;
  } btn_state_t;

  localparam int BTN_ST_W = $bits(btn_state_t);
  localparam btn_state_t BTN_RESET = '{raw: 1'b1, stable: 1'b1, ctime: '0};

  typedef struct packed {
    logic               kind;
    logic               state;
    logic [BTN_W-1:0]   button;
    logic [RELAY_W-1:0] relay;
  } notice_t;

  localparam int NOTICE_W = $bits(notice_t);

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [BTN_W-1:0]   button_index;
    logic               level;
    logic [TIME_W-1:0]  now_ms;
    logic               relay_ok;
    logic [RELAY_W-1:0] relay_index;
    logic               sync_value;
  } item_t;

  typedef struct packed {
    logic               press_detected;
    logic               relay_cmd_valid;
    logic [RELAY_W-1:0] relay_cmd_index;
    logic               relay_cmd_value;
    logic               notify_dropped;
    logic               notify_valid;
    logic               notify_kind;
    logic               notify_state;
    logic [BTN_W-1:0]   notify_button;
    logic [RELAY_W-1:0] notify_relay;
    logic [CNT_W-1:0]   queue_count;
  } result_t;

endpackage

>>> hdl/bdtn_in_if.sv
// Input channel: one operation beat.
interface bdtn_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdtn_pkg::OP_W-1:0]      operation;
  logic [bdtn_pkg::BTN_W-1:0]     button_index;
  logic                           level;
  logic [bdtn_pkg::TIME_W-1:0]    now_ms;
  logic                           relay_ok;
  logic [bdtn_pkg::RELAY_W-1:0]   relay_index;
  logic                           sync_value;

  modport source (
    output valid, operation, button_index, level, now_ms, relay_ok, relay_index, sync_value,
    input  ready
  );
  modport sink (
    input  valid, operation, button_index, level, now_ms, relay_ok, relay_index, sync_value,
    output ready
  );
endinterface

>>> hdl/bdtn_out_if.sv
// Output channel: one result beat.
interface bdtn_out_if;
  logic                           valid;
  logic                           ready;
  logic                           press_detected;
  logic                           relay_cmd_valid;
  logic [bdtn_pkg::RELAY_W-1:0]   relay_cmd_index;
  logic                           relay_cmd_value;
  logic                           notify_dropped;
  logic                           notify_valid;
  logic                           notify_kind;
  logic                           notify_state;
  logic [bdtn_pkg::BTN_W-1:0]     notify_button;
  logic [bdtn_pkg::RELAY_W-1:0]   notify_relay;
  logic [bdtn_pkg::CNT_W-1:0]     queue_count;

  modport source (
    output valid, press_detected, relay_cmd_valid, relay_cmd_index, relay_cmd_value,
           notify_dropped, notify_valid, notify_kind, notify_state, notify_button,
           notify_relay, queue_count,
    input  ready
  );
  modport sink (
    input  valid, press_detected, relay_cmd_valid, relay_cmd_index, relay_cmd_value,
           notify_dropped, notify_valid, notify_kind, notify_state, notify_button,
           notify_relay, queue_count,
    output ready
  );
endinterface

>>> hdl/bdtn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdtn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bdtn_cfg.sv
// APB configuration registers.
module bdtn_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdtn_pkg::CFG_AW-1:0]   paddr,
  input  logic [bdtn_pkg::CFG_DW-1:0]   pwdata,
  output logic [bdtn_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output bdtn_pkg::cfg_t                cfg_o
);

  bdtn_pkg::cfg_t                       cfg_q, cfg_d;
  logic [bdtn_pkg::REG_IDX_W-1:0]       idx;
  logic                                 wr;

  assign idx    = paddr[bdtn_pkg::CFG_AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        bdtn_pkg::REG_BUTTON_COUNT: cfg_d.button_count = pwdata[bdtn_pkg::CNT_W-1:0];
        bdtn_pkg::REG_ENABLE_MASK:  cfg_d.enable_mask  = pwdata[bdtn_pkg::NUM_BUTTONS-1:0];
        bdtn_pkg::REG_LOCAL_MASK:   cfg_d.local_mask   = pwdata[bdtn_pkg::NUM_BUTTONS-1:0];
        bdtn_pkg::REG_RELAY_MAP:    cfg_d.relay_map    = pwdata[bdtn_pkg::MAP_W-1:0];
        bdtn_pkg::REG_DEBOUNCE_MS:  cfg_d.debounce_ms  = pwdata[bdtn_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      bdtn_pkg::REG_BUTTON_COUNT: prdata = bdtn_pkg::CFG_DW'(cfg_q.button_count);
      bdtn_pkg::REG_ENABLE_MASK:  prdata = bdtn_pkg::CFG_DW'(cfg_q.enable_mask);
      bdtn_pkg::REG_LOCAL_MASK:   prdata = bdtn_pkg::CFG_DW'(cfg_q.local_mask);
      bdtn_pkg::REG_RELAY_MAP:    prdata = bdtn_pkg::CFG_DW'(cfg_q.relay_map);
      bdtn_pkg::REG_DEBOUNCE_MS:  prdata = bdtn_pkg::CFG_DW'(cfg_q.debounce_ms);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.debounce_ms  <= bdtn_pkg::DEBOUNCE_RESET_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hdl/button_debounce_toggle_notifier.sv
// An accepted input beat is registered into stage 1 and its result into out_q.
// Throughput: one beat per cycle while the output is not stalled; the button-state
// RAM read is issued on accept, the read-modify-write completes in stage 1 with
// same-entry forwarding. The notice ring RAM is read at the next tail on accept and
// forwarded on a same-slot push. Reset: all buttons held, relays off, ring empty,
// no clearing pass (per-button valid flops stand in for the RAM contents).
module button_debounce_toggle_notifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bdtn_in_if.sink                       in_if,
  bdtn_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdtn_pkg::CFG_AW-1:0]   paddr,
  input  logic [bdtn_pkg::CFG_DW-1:0]   pwdata,
  output logic [bdtn_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int NB = bdtn_pkg::NUM_BUTTONS;
  localparam int RW = bdtn_pkg::RELAY_W;

  bdtn_pkg::cfg_t      cfg;
  bdtn_pkg::item_t     in_item;
  bdtn_pkg::item_t     s1_q;
  logic                s1_valid_q;
  bdtn_pkg::result_t   out_q, res;
  logic                out_valid_q;
  logic                in_accept, s1_fire;

  // button state RAM and forwarding
  logic                              btn_we;
  bdtn_pkg::btn_state_t              btn_wdata;
  logic [bdtn_pkg::BTN_ST_W-1:0]     btn_rdata;
  logic                              btn_fwd_q;
  bdtn_pkg::btn_state_t              btn_fwd_data_q;
  logic [NB-1:0]                     btn_vld_q;

  // ring RAM and pointers
  logic                              ring_we;
  bdtn_pkg::notice_t                 ring_wdata;
  logic [bdtn_pkg::NOTICE_W-1:0]     ring_rdata;
  logic                              ring_fwd_q;
  bdtn_pkg::notice_t                 ring_fwd_data_q;
  logic [bdtn_pkg::RING_AW-1:0]      head_q, head_d, tail_q, tail_d;

  logic [NB-1:0]                     mirror_q, mirror_d;

  bdtn_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_item = '{operation:    in_if.operation,
                     button_index: in_if.button_index,
                     level:        in_if.level,
                     now_ms:       in_if.now_ms,
                     relay_ok:     in_if.relay_ok,
                     relay_index:  in_if.relay_index,
                     sync_value:   in_if.sync_value};

  assign s1_fire     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_fire;
  assign in_accept   = in_if.valid && in_if.ready;

  bdtn_ram #(
    .WIDTH (bdtn_pkg::BTN_ST_W),
    .DEPTH (NB)
  ) u_btn_ram (
    .clk_i   (clk_i),
    .we_i    (btn_we),
    .waddr_i (s1_q.button_index),
    .wdata_i (btn_wdata),
    .re_i    (in_accept),
    .raddr_i (in_if.button_index),
    .rdata_o (btn_rdata)
  );

  bdtn_ram #(
    .WIDTH (bdtn_pkg::NOTICE_W),
    .DEPTH (bdtn_pkg::RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (head_q),
    .wdata_i (ring_wdata),
    .re_i    (in_accept),
    .raddr_i (tail_d),
    .rdata_o (ring_rdata)
  );

  // stage 1: read-modify-write of the button entry and ring update
  always_comb begin
    logic [bdtn_pkg::CNT_W-1:0]   active;
    logic                         en;
    bdtn_pkg::btn_state_t         cur;
    bdtn_pkg::btn_state_t         nxt;
    logic [bdtn_pkg::TIME_W-1:0]  elapsed;
    logic [RW-1:0]                rly;
    logic                         nv;
    logic                         push;
    logic                         full;
    bdtn_pkg::notice_t            pop_e;

    active = (cfg.button_count > bdtn_pkg::CNT_W'(NB)) ? bdtn_pkg::CNT_W'(NB)
                                                       : cfg.button_count;
    en = (bdtn_pkg::CNT_W'(s1_q.button_index) < active) &&
         cfg.enable_mask[s1_q.button_index];
    cur = btn_fwd_q ? btn_fwd_data_q :
          (btn_vld_q[s1_q.button_index] ? bdtn_pkg::btn_state_t'(btn_rdata)
                                        : bdtn_pkg::BTN_RESET);
    nxt = cur;
    rly = cfg.relay_map[s1_q.button_index*RW +: RW];
    nv  = !mirror_q[s1_q.button_index];
    push = 1'b0;
    full = ((head_q + 1'b1) == tail_q);
    pop_e = ring_fwd_q ? ring_fwd_data_q : bdtn_pkg::notice_t'(ring_rdata);
    elapsed = '0;

    res        = '0;
    ring_wdata = '0;
    mirror_d   = mirror_q;
    head_d     = head_q;
    tail_d     = tail_q;

    case (s1_q.operation)
      bdtn_pkg::OP_SAMPLE: begin
        if (en) begin
          if (s1_q.level != cur.raw) begin
            nxt.ctime = s1_q.now_ms;
            nxt.raw   = s1_q.level;
          end
          elapsed = s1_q.now_ms - nxt.ctime;
          if (elapsed > bdtn_pkg::TIME_W'(cfg.debounce_ms)) begin
            if (!cur.stable && s1_q.level) begin
              res.press_detected = 1'b1;
              if (cfg.local_mask[s1_q.button_index]) begin
                res.relay_cmd_valid = 1'b1;
                res.relay_cmd_index = rly;
                res.relay_cmd_value = nv;
                if (s1_q.relay_ok) begin
                  mirror_d[s1_q.button_index] = nv;
                  push = 1'b1;
                  ring_wdata = '{kind: bdtn_pkg::KIND_LOCAL, state: nv,
                                 button: s1_q.button_index, relay: rly};
                end
              end else begin
                push = 1'b1;
                ring_wdata = '{kind: bdtn_pkg::KIND_REMOTE, state: 1'b0,
                               button: s1_q.button_index, relay: rly};
              end
            end
            nxt.stable = s1_q.level;
          end
        end
      end
      bdtn_pkg::OP_SYNC: begin
        for (int i = 0; i < NB; i++) begin
          if ((bdtn_pkg::CNT_W'(i) < active) &&
              (cfg.relay_map[i*RW +: RW] == s1_q.relay_index)) begin
            mirror_d[i] = s1_q.sync_value;
          end
        end
      end
      bdtn_pkg::OP_POP: begin
        if (tail_q != head_q) begin
          res.notify_valid  = 1'b1;
          res.notify_kind   = pop_e.kind;
          res.notify_state  = pop_e.state;
          res.notify_button = pop_e.button;
          res.notify_relay  = pop_e.relay;
          tail_d = tail_q + 1'b1;
        end
      end
      default: ;
    endcase

    if (push) begin
      if (full) begin
        res.notify_dropped = 1'b1;
      end else begin
        head_d = head_q + 1'b1;
      end
    end

    ring_we   = s1_fire && push && !full;
    btn_we    = s1_fire && (s1_q.operation == bdtn_pkg::OP_SAMPLE) && en;
    btn_wdata = nxt;

    if (!s1_fire) begin
      head_d   = head_q;
      tail_d   = tail_q;
      mirror_d = mirror_q;
    end
    res.queue_count = bdtn_pkg::CNT_W'(head_d - tail_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      mirror_q    <= '0;
      btn_vld_q   <= '0;
      btn_fwd_q   <= 1'b0;
      ring_fwd_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      head_q   <= head_d;
      tail_q   <= tail_d;
      mirror_q <= mirror_d;
      if (btn_we) begin
        btn_vld_q[s1_q.button_index] <= 1'b1;
      end
      // catch a write landing on the entry being read this edge
      if (in_accept) begin
        btn_fwd_q  <= btn_we && (s1_q.button_index == in_if.button_index);
        ring_fwd_q <= ring_we && (head_q == tail_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q            <= in_item;
      btn_fwd_data_q  <= btn_wdata;
      ring_fwd_data_q <= ring_wdata;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.press_detected  = out_q.press_detected;
  assign out_if.relay_cmd_valid = out_q.relay_cmd_valid;
  assign out_if.relay_cmd_index = out_q.relay_cmd_index;
  assign out_if.relay_cmd_value = out_q.relay_cmd_value;
  assign out_if.notify_dropped  = out_q.notify_dropped;
  assign out_if.notify_valid    = out_q.notify_valid;
  assign out_if.notify_kind     = out_q.notify_kind;
  assign out_if.notify_state    = out_q.notify_state;
  assign out_if.notify_button   = out_q.notify_button;
  assign out_if.notify_relay    = out_q.notify_relay;
  assign out_if.queue_count     = out_q.queue_count;

endmodule
